// ----- design/fir_filter_circular_macros.svh -----
// assertion macros for the circular fir filter
`ifndef FIR_FILTER_CIRCULAR_MACROS_SVH
`define FIR_FILTER_CIRCULAR_MACROS_SVH

// same-cycle implication, disabled in reset
`define FIR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define FIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/fir_pkg.sv -----
// package with sizes, types and helpers of the circular fir filter
package fir_pkg;

  localparam int TAPS         = 16;
  localparam int SAMPLE_WIDTH = 24;
  localparam int COEF_WIDTH   = 24;

  localparam int TAPS_CFG_W = 5;
  localparam int COEF_IDX_W = 4;
  localparam int IDX_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int LOG_TAPS   = (TAPS > 1) ? $clog2(TAPS) : 0;
  localparam int PROD_W     = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W      = PROD_W + LOG_TAPS;
  localparam int FRAC_SHIFT = COEF_WIDTH - 2;

  localparam logic [TAPS_CFG_W-1:0] TAPS_RESET = TAPS_CFG_W'(16);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef logic signed [ACC_W-1:0]        acc_t;
  typedef logic signed [ACC_W:0]          rnd_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // item kind codes
  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_COEF   = 1'b1
  } kind_t;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic issue;
    logic round;
  } mac_ctl_t;

  // sequencer status
  typedef struct packed {
    logic busy;
    logic load;
  } seq_stat_t;

  // index of the last tap in use, tap count clamped to 1..TAPS
  function automatic logic [IDX_W-1:0] last_tap(input logic [TAPS_CFG_W-1:0] cfg);
    logic [IDX_W-1:0] r;
    if (cfg == '0) begin
      r = '0;
    end else if (32'(cfg) > TAPS) begin
      r = IDX_W'(TAPS - 1);
    end else begin
      r = IDX_W'(cfg - 1'b1);
    end
    return r;
  endfunction

endpackage

// ----- design/fir_ifs.sv -----
// valid/ready channel interfaces of the circular fir filter

// input items: samples and coefficient writes
interface fir_in_if import fir_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  kind;
  sample_t               sample_in;
  logic [COEF_IDX_W-1:0] coef_index;
  coef_t                 coef_value;

  modport source (output valid, kind, sample_in, coef_index, coef_value, input ready);
  modport sink   (input valid, kind, sample_in, coef_index, coef_value, output ready);
endinterface

// result items: filtered samples
interface fir_out_if import fir_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

// ----- design/fir_ram.sv -----
// single-port-write, registered-read ram with per-entry valid bits cleared on reset
module fir_ram #(
  parameter  int WIDTH = 24,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] rd_q;
  logic             rd_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q  <= mem[raddr];
    rd_ok <= vld[raddr];
  end

  // entries never written read as zero
  assign rdata = rd_ok ? rd_q : '0;

endmodule

// ----- design/fir_mac.sv -----
// shared multiply-accumulate unit with rounding and saturation
module fir_mac import fir_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  sample_t  x,
  input  coef_t    c,
  input  mac_ctl_t ctl,
  output sample_t  y
);

  localparam rnd_t RND_HALF = {{(ACC_W + 1 - FRAC_SHIFT){1'b0}}, 1'b1,
                               {(FRAC_SHIFT-1){1'b0}}};

  logic  dvld;
  logic  pvld;
  prod_t prod;
  acc_t  acc;
  rnd_t  rnd;
  rnd_t  shifted;
  logic [ACC_W-SAMPLE_WIDTH+1:0] upper;

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld <= 1'b0;
      pvld <= 1'b0;
    end else begin
      dvld <= ctl.issue;
      pvld <= dvld;
    end
  end

  always_ff @(posedge clk) begin
    if (dvld) begin
      prod <= x * c;
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (pvld) begin
      acc <= acc + ACC_W'(prod);
    end
    if (ctl.round) begin
      rnd <= (ACC_W+1)'(acc) + RND_HALF;
    end
  end

  // drop fraction bits, then clamp to the sample range
  always_comb begin
    shifted = rnd >>> FRAC_SHIFT;
    upper   = shifted[ACC_W:SAMPLE_WIDTH-1];
    if ((&upper) || !(|upper)) begin
      y = shifted[SAMPLE_WIDTH-1:0];
    end else if (rnd[ACC_W]) begin
      y = SAMPLE_MIN;
    end else begin
      y = SAMPLE_MAX;
    end
  end

endmodule

// ----- design/fir_seq.sv -----
// sequencer: tap count, write position and the per-tap read sweep
module fir_seq import fir_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  out_free,
  input  logic                  cfg_we,
  input  logic [TAPS_CFG_W-1:0] cfg_data,
  output logic                  idle,
  output logic [IDX_W-1:0]      wr_pos,
  output logic [IDX_W-1:0]      rd_pos,
  output logic [IDX_W-1:0]      rd_tap,
  output mac_ctl_t              mac_ctl,
  output seq_stat_t             stat
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RUN   = 5'b00010,
    S_FLUSH = 5'b00100,
    S_ROUND = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                  state;
  logic [TAPS_CFG_W-1:0]   taps;
  logic [IDX_W-1:0]        wp;
  logic [IDX_W-1:0]        pos;
  logic [IDX_W-1:0]        tap;
  logic                    flush;
  logic [IDX_W-1:0]        last;

  assign last = last_tap(taps);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      taps  <= TAPS_RESET;
      wp    <= last_tap(TAPS_RESET);
      pos   <= '0;
      tap   <= '0;
      flush <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            pos   <= wp;
            tap   <= '0;
            wp    <= (wp == '0) ? last : wp - 1'b1;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (tap == last) begin
            flush <= 1'b0;
            state <= S_FLUSH;
          end else begin
            tap <= tap + 1'b1;
            pos <= (pos == last) ? '0 : pos + 1'b1;
          end
        end
        S_FLUSH: begin
          if (flush) begin
            state <= S_ROUND;
          end else begin
            flush <= 1'b1;
          end
        end
        S_ROUND: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // new tap count restarts the write position
      if (cfg_we) begin
        taps <= cfg_data;
        wp   <= last_tap(cfg_data);
      end
    end
  end

  assign idle          = (state == S_IDLE);
  assign wr_pos        = wp;
  assign rd_pos        = pos;
  assign rd_tap        = tap;
  assign mac_ctl.clear = idle && start;
  assign mac_ctl.issue = (state == S_RUN);
  assign mac_ctl.round = (state == S_ROUND);
  assign stat.busy     = !idle;
  assign stat.load     = (state == S_DONE) && out_free;

endmodule

// ----- design/fir_filter_circular.sv -----
// top level of the direct-form fir filter over a circular delay line
//
//   channel  dir  kind             payload
//   din      in   valid/ready      kind, sample_in, coef_index, coef_value
//   dout     out  valid/ready      sample_out
//   cfg      in   write enable     cfg_data = taps_in_use
//
// a coefficient item gives no result and leaves the input ready
// a sample item reads the delay line and coefficient rams once per tap in use (taps_in_use
//   held to 1..16) into the single multiplier, then runs the pipeline flush, a rounding
//   step and the output load
// reset clears the delay line and coefficients through valid bits, sets 16 taps
// a stalled result sits in the output register; the next sample can run meanwhile
//   and holds in its load cycle, with the input not ready, until the register frees
module fir_filter_circular import fir_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  fir_in_if.sink                din,
  fir_out_if.source             dout,
  input  logic                  cfg_we,
  input  logic [TAPS_CFG_W-1:0] cfg_data
);

`include "fir_filter_circular_macros.svh"

  logic       accept;
  logic       start;
  logic       coef_take;
  logic       coef_we;
  logic       idle;
  logic       out_free;
  logic [IDX_W-1:0] wr_pos;
  logic [IDX_W-1:0] rd_pos;
  logic [IDX_W-1:0] rd_tap;
  mac_ctl_t   mac_ctl;
  seq_stat_t  stat;
  sample_t    x_rd;
  coef_t      c_rd;
  sample_t    y;
  logic       out_vld;
  sample_t    out_data;

  // item handshake: only idle between samples
  assign din.ready = idle;
  assign accept    = din.valid && din.ready;
  assign start     = accept && (din.kind == KIND_SAMPLE);
  assign coef_take = accept && (din.kind == KIND_COEF);
  // coefficient indices past the storage are dropped
  assign coef_we   = coef_take && (32'(din.coef_index) < TAPS);

  // result register frees up when the consumer takes the item
  assign out_free  = !out_vld || dout.ready;

  fir_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .idle     (idle),
    .wr_pos   (wr_pos),
    .rd_pos   (rd_pos),
    .rd_tap   (rd_tap),
    .mac_ctl  (mac_ctl),
    .stat     (stat)
  );

  // delay line: new sample lands at the write position on accept
  fir_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(TAPS)) u_delay (
    .clk   (clk),
    .rst   (rst),
    .we    (start),
    .waddr (wr_pos),
    .wdata (din.sample_in),
    .raddr (rd_pos),
    .rdata (x_rd)
  );

  // coefficient store
  fir_ram #(.WIDTH(COEF_WIDTH), .DEPTH(TAPS)) u_coef (
    .clk   (clk),
    .rst   (rst),
    .we    (coef_we),
    .waddr (IDX_W'(din.coef_index)),
    .wdata (din.coef_value),
    .raddr (rd_tap),
    .rdata (c_rd)
  );

  fir_mac u_mac (
    .clk (clk),
    .rst (rst),
    .x   (x_rd),
    .c   (c_rd),
    .ctl (mac_ctl),
    .y   (y)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (stat.load) begin
      out_vld <= 1'b1;
    end else if (dout.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.load) begin
      out_data <= y;
    end
  end

  assign dout.valid      = out_vld;
  assign dout.sample_out = out_data;

  // a sample item starts the tap sweep
  `FIR_ASSERT_NEXT(a_sample_starts, clk, rst, start, stat.busy, "sample item did not start")
  // a coefficient item leaves the block ready
  `FIR_ASSERT_NEXT(a_coef_one_cycle, clk, rst, coef_take, din.ready, "coefficient item stalled")
  // a result only appears at the end of a sweep
  `FIR_ASSERT_NOW(a_result_from_sweep, clk, rst, $rose(dout.valid), $past(stat.busy), "stray result")

endmodule
